// ===== sv/bmm_pkg.sv =====
// Package for the bracket match marker: controller states, mark codes,
// character constants and the command and status structs.
// No dependencies.
`default_nettype none

package bmm_pkg;

    localparam logic [7:0] CH_OPEN  = 8'h28;
    localparam logic [7:0] CH_CLOSE = 8'h29;

    localparam logic [1:0] MARK_BLANK  = 2'd0;
    localparam logic [1:0] MARK_DOLLAR = 2'd1;
    localparam logic [1:0] MARK_QUEST  = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_POP,
        ST_SCAN_RD,
        ST_SCAN_CHK,
        ST_EMIT_RD,
        ST_EMIT_LD,
        ST_OUT
    } bmm_state_t;

    typedef struct packed {
        logic take;
        logic pop_clear;
        logic scan_start;
        logic scan_step;
        logic emit_start;
        logic load_mark;
        logic load_bare;
        logic idx_inc;
        logic line_clear;
    } bmm_cmd_t;

    typedef struct packed {
        logic pop;
        logic scan_end;
        logic found;
        logic done;
    } bmm_sts_t;

endpackage

`default_nettype wire

// ===== sv/bmm_in_if.sv =====
// Input channel of the bracket match marker: one character item per handshake.
// No dependencies.
`default_nettype none

interface bmm_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       line_last;
    logic       line_empty;

    modport source (output valid, char_code, line_last, line_empty, input ready);
    modport sink   (input valid, char_code, line_last, line_empty, output ready);
endinterface

`default_nettype wire

// ===== sv/bmm_out_if.sv =====
// Output channel of the bracket match marker: one mark item per handshake.
// No dependencies.
`default_nettype none

interface bmm_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] mark_code;
    logic       mark_valid;
    logic       line_done;

    modport source (output valid, mark_code, mark_valid, line_done, input ready);
    modport sink   (input valid, mark_code, mark_valid, line_done, output ready);
endinterface

`default_nettype wire

// ===== sv/bmm_ctrl.sv =====
// Controller of the bracket match marker: sequences character intake, the
// partner clear, the mark scan and the emission. Depends on bmm_pkg.
`default_nettype none

module bmm_ctrl
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    input  wire logic              in_line_last,
    input  wire logic              in_line_empty,
    output logic                   in_ready,
    input  wire logic              out_ready,
    output logic                   out_valid,
    input  wire bmm_pkg::bmm_sts_t sts,
    output bmm_pkg::bmm_cmd_t      cmd
);

    bmm_pkg::bmm_state_t state_reg;
    bmm_pkg::bmm_state_t state_next;
    logic                last_pend_reg;
    logic                last_pend_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bmm_pkg::ST_IDLE;
            last_pend_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            last_pend_reg <= last_pend_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        last_pend_next = last_pend_reg;
        unique case (state_reg)
            bmm_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    last_pend_next = in_line_last;
                    priority if (in_line_empty)
                        state_next = bmm_pkg::ST_SCAN_RD;
                    else if (sts.pop)
                        state_next = bmm_pkg::ST_POP;
                    else if (in_line_last)
                        state_next = bmm_pkg::ST_SCAN_RD;
                    else
                        state_next = bmm_pkg::ST_IDLE;
                end
            end
            bmm_pkg::ST_POP:
            begin
                state_next = last_pend_reg ? bmm_pkg::ST_SCAN_RD : bmm_pkg::ST_IDLE;
            end
            bmm_pkg::ST_SCAN_RD:
            begin
                priority if (!sts.scan_end)
                    state_next = bmm_pkg::ST_SCAN_CHK;
                else if (sts.found)
                    state_next = bmm_pkg::ST_EMIT_RD;
                else
                    state_next = bmm_pkg::ST_OUT;
            end
            bmm_pkg::ST_SCAN_CHK:
            begin
                state_next = bmm_pkg::ST_SCAN_RD;
            end
            bmm_pkg::ST_EMIT_RD:
            begin
                state_next = bmm_pkg::ST_EMIT_LD;
            end
            bmm_pkg::ST_EMIT_LD:
            begin
                state_next = bmm_pkg::ST_OUT;
            end
            bmm_pkg::ST_OUT:
            begin
                if (out_ready)
                begin
                    state_next = sts.done ? bmm_pkg::ST_IDLE : bmm_pkg::ST_EMIT_RD;
                end
            end
            default:
            begin
                state_next = bmm_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd       = '0;
        in_ready  = 1'b0;
        out_valid = 1'b0;
        unique case (state_reg)
            bmm_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.take       = !in_line_empty;
                    cmd.scan_start = in_line_empty || (in_line_last && !sts.pop);
                end
            end
            bmm_pkg::ST_POP:
            begin
                cmd.pop_clear  = 1'b1;
                cmd.scan_start = last_pend_reg;
            end
            bmm_pkg::ST_SCAN_RD:
            begin
                if (sts.scan_end)
                begin
                    cmd.emit_start = sts.found;
                    cmd.load_bare  = !sts.found;
                end
            end
            bmm_pkg::ST_SCAN_CHK:
            begin
                cmd.scan_step = 1'b1;
            end
            bmm_pkg::ST_EMIT_RD:
            begin
                cmd = '0;
            end
            bmm_pkg::ST_EMIT_LD:
            begin
                cmd.load_mark = 1'b1;
            end
            bmm_pkg::ST_OUT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    cmd.idx_inc    = 1'b1;
                    cmd.line_clear = sts.done;
                end
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== sv/bmm_dp.sv =====
// Datapath of the bracket match marker: mark and open-bracket memories,
// line and stack counters, scan bounds and the output item register.
// Depends on bmm_pkg.
`default_nettype none

module bmm_dp
#(
    parameter int MAX_LEN = 64
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic [7:0]        char_code,
    input  wire bmm_pkg::bmm_cmd_t cmd,
    output bmm_pkg::bmm_sts_t      sts,
    output logic [1:0]             mark_code,
    output logic                   mark_valid,
    output logic                   line_done
);

    localparam int PW = $clog2(MAX_LEN);
    localparam int CW = $clog2(MAX_LEN + 1);

    logic [1:0]    mark_mem [MAX_LEN];
    logic [PW-1:0] stack_mem [MAX_LEN];

    logic [CW-1:0] len_reg;
    logic [CW-1:0] len_next;
    logic [CW-1:0] sd_reg;
    logic [CW-1:0] sd_next;
    logic [CW-1:0] idx_reg;
    logic [CW-1:0] idx_next;
    logic [PW-1:0] stk_rd_reg;
    logic [1:0]    mark_rd_reg;
    logic [PW-1:0] first_reg;
    logic [PW-1:0] last_reg;
    logic          found_reg;
    logic [1:0]    mark_code_reg;
    logic          mark_valid_reg;
    logic          line_done_reg;

    logic          full;
    logic          is_open;
    logic          is_close;
    logic          stack_nz;
    logic          take_ok;
    logic [1:0]    mark_new;
    logic [PW-1:0] sd_top;
    logic          mark_we;
    logic [PW-1:0] mark_waddr;
    logic [1:0]    mark_wdata;
    logic          scan_hit;

    assign full     = (len_reg == CW'(MAX_LEN));
    assign is_open  = (char_code == bmm_pkg::CH_OPEN);
    assign is_close = (char_code == bmm_pkg::CH_CLOSE);
    assign stack_nz = (sd_reg != '0);
    assign take_ok  = cmd.take && !full;
    assign sd_top   = PW'(sd_reg - CW'(1));
    assign scan_hit = (mark_rd_reg != bmm_pkg::MARK_BLANK);

    always_comb
    begin
        priority if (is_open)
            mark_new = bmm_pkg::MARK_DOLLAR;
        else if (is_close && !stack_nz)
            mark_new = bmm_pkg::MARK_QUEST;
        else
            mark_new = bmm_pkg::MARK_BLANK;
    end

    assign mark_we    = take_ok || cmd.pop_clear;
    assign mark_waddr = cmd.pop_clear ? stk_rd_reg : len_reg[PW-1:0];
    assign mark_wdata = cmd.pop_clear ? bmm_pkg::MARK_BLANK : mark_new;

    always_ff @(posedge clk)
    begin
        if (mark_we)
        begin
            mark_mem[mark_waddr] <= mark_wdata;
        end
        mark_rd_reg <= mark_mem[idx_reg[PW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (take_ok && is_open)
        begin
            stack_mem[sd_reg[PW-1:0]] <= len_reg[PW-1:0];
        end
        stk_rd_reg <= stack_mem[sd_top];
    end

    always_comb
    begin
        len_next = len_reg;
        sd_next  = sd_reg;
        priority if (cmd.line_clear)
        begin
            len_next = '0;
            sd_next  = '0;
        end
        else if (take_ok)
        begin
            len_next = len_reg + CW'(1);
            if (is_open)
                sd_next = sd_reg + CW'(1);
            else if (is_close && stack_nz)
                sd_next = sd_reg - CW'(1);
        end
    end

    always_comb
    begin
        idx_next = idx_reg;
        priority if (cmd.scan_start)
            idx_next = '0;
        else if (cmd.emit_start)
            idx_next = CW'(first_reg);
        else if (cmd.scan_step || cmd.idx_inc)
            idx_next = idx_reg + CW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg <= '0;
            sd_reg  <= '0;
            idx_reg <= '0;
        end
        else
        begin
            len_reg <= len_next;
            sd_reg  <= sd_next;
            idx_reg <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.scan_start)
        begin
            found_reg <= 1'b0;
        end
        else if (cmd.scan_step && scan_hit)
        begin
            found_reg <= 1'b1;
            last_reg  <= idx_reg[PW-1:0];
            if (!found_reg)
            begin
                first_reg <= idx_reg[PW-1:0];
            end
        end

        if (cmd.load_bare)
        begin
            mark_code_reg  <= bmm_pkg::MARK_BLANK;
            mark_valid_reg <= 1'b0;
            line_done_reg  <= 1'b1;
        end
        else if (cmd.load_mark)
        begin
            mark_code_reg  <= mark_rd_reg;
            mark_valid_reg <= 1'b1;
            line_done_reg  <= (idx_reg[PW-1:0] == last_reg);
        end
    end

    assign sts.pop      = is_close && stack_nz && !full;
    assign sts.scan_end = (idx_reg == len_reg);
    assign sts.found    = found_reg;
    assign sts.done     = line_done_reg;

    assign mark_code  = mark_code_reg;
    assign mark_valid = mark_valid_reg;
    assign line_done  = line_done_reg;

endmodule

`default_nettype wire

// ===== sv/bracket_match_marker.sv =====
// Bracket match marker: one line of characters in, the span of unmatched
// bracket marks out. Depends on bmm_pkg, bmm_in_if, bmm_out_if, bmm_ctrl, bmm_dp.
//
// The input channel takes one character item per handshake, with line_last on
// the final character, or a line_empty item that ends the line alone. Each '('
// is pushed on a stack of pending positions and each ')' pops its partner, if
// any. A ')' that finds a partner passes through a further pop state, as the
// partner's mark is cleared through the single write port of the mark memory.
// Characters beyond MAX_LEN positions are dropped, though line_last still ends
// the line.
// At line end the mark memory is scanned, one stored position per read and check
// state pair, to find the first and last non-blank marks. The marks in that
// span then leave one item at a time, each read through the emit read and load
// states, the cost of the registered memory read. A line with no marks gives
// one bare item with line_done set. The block works on one line at a time: the
// input is not ready from line end until the final result is taken. A stalled
// receiver holds the output item. Reset empties the line and the stack; the
// memories are not cleared.
`default_nettype none

module bracket_match_marker
#(
    parameter int MAX_LEN = 64
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    bmm_in_if.sink    in_ch,
    bmm_out_if.source out_ch
);

    bmm_pkg::bmm_cmd_t cmd;
    bmm_pkg::bmm_sts_t sts;
    logic              in_ready;
    logic              out_valid;
    logic [1:0]        mark_code;
    logic              mark_valid;
    logic              line_done;

    bmm_ctrl u_ctrl
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_ch.valid),
        .in_line_last  (in_ch.line_last),
        .in_line_empty (in_ch.line_empty),
        .in_ready      (in_ready),
        .out_ready     (out_ch.ready),
        .out_valid     (out_valid),
        .sts           (sts),
        .cmd           (cmd)
    );

    bmm_dp #(.MAX_LEN(MAX_LEN)) u_dp
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .char_code  (in_ch.char_code),
        .cmd        (cmd),
        .sts        (sts),
        .mark_code  (mark_code),
        .mark_valid (mark_valid),
        .line_done  (line_done)
    );

    assign in_ch.ready       = in_ready;
    assign out_ch.valid      = out_valid;
    assign out_ch.mark_code  = mark_code;
    assign out_ch.mark_valid = mark_valid;
    assign out_ch.line_done  = line_done;

endmodule

`default_nettype wire

// ===== sv/bmm_checker.sv =====
// Port checker for the bracket match marker and its bind to the top level.
// Depends on bmm_pkg and bracket_match_marker.
`default_nettype none

module bmm_checker
(
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       in_ready,
    input wire logic       out_valid,
    input wire logic       out_ready,
    input wire logic [1:0] mark_code,
    input wire logic       mark_valid,
    input wire logic       line_done
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("Output item withdrawn before it was taken.");

    a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready)
        else $error("Input ready while a result item is pending.");

    a_bare_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !mark_valid |-> line_done && (mark_code == bmm_pkg::MARK_BLANK))
        else $error("Bare line end is not a blank final item.");

    a_code_legal: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (mark_code == bmm_pkg::MARK_BLANK || mark_code == bmm_pkg::MARK_DOLLAR
                       || mark_code == bmm_pkg::MARK_QUEST))
        else $error("Mark code out of range.");

    a_line_gap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && line_done |=> !out_valid)
        else $error("Result item follows the end of a line.");

endmodule

bind bracket_match_marker bmm_checker u_bmm_checker
(
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ready   (in_ch.ready),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .mark_code  (out_ch.mark_code),
    .mark_valid (out_ch.mark_valid),
    .line_done  (out_ch.line_done)
);

`default_nettype wire

// ===== bench/bmm_mark_checker.sv =====
`timescale 1ns / 100ps
// Checker for the bracket match marker: watches both channels, predicts the marks
// of each line and compares every output item in order. Depends on bmm_pkg,
// bmm_in_if and bmm_out_if.

module bmm_mark_checker
#(
    parameter int LINE_CAP = 64
)
(
    input  logic clk,
    input  logic rst_n,
    bmm_in_if    in_ch,
    bmm_out_if   out_ch,
    output int   failures,
    output int   pending,
    output int   lines_checked,
    output int   marks_checked
);

    typedef struct packed {
        logic [1:0] code;
        logic       valid;
        logic       done;
    } mark_item_t;

    logic [1:0]  line_marks [LINE_CAP];
    logic [5:0]  open_pos [LINE_CAP];
    int unsigned open_count;
    int unsigned line_len;
    mark_item_t  awaited_marks [$];

    task automatic add_char(input logic [7:0] ch);
        logic [1:0] mark;
        mark = bmm_pkg::MARK_BLANK;
        if (line_len < LINE_CAP)
        begin
            if (ch == bmm_pkg::CH_OPEN)
            begin
                open_pos[open_count] = 6'(line_len);
                open_count++;
                mark = bmm_pkg::MARK_DOLLAR;
            end
            else if (ch == bmm_pkg::CH_CLOSE)
            begin
                if (open_count > 0)
                begin
                    open_count--;
                    line_marks[open_pos[open_count]] = bmm_pkg::MARK_BLANK;
                end
                else
                begin
                    mark = bmm_pkg::MARK_QUEST;
                end
            end
            line_marks[line_len] = mark;
            line_len++;
        end
    endtask

    task automatic close_line();
        int first_pos;
        int last_pos;
        int i;
        first_pos = -1;
        last_pos = -1;
        for (i = 0; i < int'(line_len); i++)
        begin
            if (line_marks[i] != bmm_pkg::MARK_BLANK)
            begin
                if (first_pos < 0)
                    first_pos = i;
                last_pos = i;
            end
        end
        if (first_pos < 0)
        begin
            awaited_marks.push_back('{bmm_pkg::MARK_BLANK, 1'b0, 1'b1});
        end
        else
        begin
            for (i = first_pos; i <= last_pos; i++)
                awaited_marks.push_back('{line_marks[i], 1'b1, i == last_pos});
        end
        line_len = 0;
        open_count = 0;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        mark_item_t want;
        if (!rst_n)
        begin
            awaited_marks.delete();
            open_count = 0;
            line_len = 0;
            failures = 0;
            pending = 0;
            lines_checked = 0;
            marks_checked = 0;
        end
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                if (awaited_marks.size() == 0)
                begin
                    failures++;
                    $display("%0t: unexpected mark item: code %0d valid %0b done %0b",
                             $time, out_ch.mark_code, out_ch.mark_valid, out_ch.line_done);
                end
                else
                begin
                    want = awaited_marks.pop_front();
                    if (out_ch.mark_code !== want.code || out_ch.mark_valid !== want.valid
                        || out_ch.line_done !== want.done)
                    begin
                        failures++;
                        $display({"%0t: mark mismatch: expected code %0d valid %0b done %0b,",
                                  " got code %0d valid %0b done %0b"},
                                 $time, want.code, want.valid, want.done,
                                 out_ch.mark_code, out_ch.mark_valid, out_ch.line_done);
                    end
                    if (want.valid)
                        marks_checked++;
                    if (want.done)
                        lines_checked++;
                end
            end
            if (in_ch.valid && in_ch.ready)
            begin
                if (in_ch.line_empty)
                begin
                    close_line();
                end
                else
                begin
                    add_char(in_ch.char_code);
                    if (in_ch.line_last)
                        close_line();
                end
            end
            pending = awaited_marks.size();
        end
    end

endmodule

// ===== bench/bracket_match_marker_test.sv =====
`timescale 1ns / 100ps
// Top of the bracket match marker bench: clock, reset, line stimulus, output
// stalls, watchdog and verdict. Depends on bmm_pkg, both channel interfaces,
// bracket_match_marker and bmm_mark_checker.

module bracket_match_marker_test;

    localparam int LINE_CAP = 64;
    localparam int RANDOM_ITEMS = 200;
    localparam int HOLD_CYCLES = 400;
    localparam int STALL_LIMIT = 3000;
    localparam int DRAIN_CYCLES = 2 * LINE_CAP + 8;

    typedef enum {
        LINE_END_LAST,
        LINE_END_EMPTY
    } line_end_t;

    logic clk;
    logic rst_n;

    bmm_in_if  in_ch();
    bmm_out_if out_ch();

    int  failures;
    int  pending;
    int  lines_checked;
    int  marks_checked;
    int  items_sent;
    int  lines_sent;
    int  idle_cycles;
    bit  send_fast;
    bit  long_hold;

    bracket_match_marker #(
        .MAX_LEN (LINE_CAP)
    ) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    bmm_mark_checker #(
        .LINE_CAP (LINE_CAP)
    ) checker_inst (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_ch         (in_ch),
        .out_ch        (out_ch),
        .failures      (failures),
        .pending       (pending),
        .lines_checked (lines_checked),
        .marks_checked (marks_checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    task automatic push_item(input logic [7:0] ch, input logic last, input logic empty);
        int unsigned gap;
        gap = send_fast ? 0 : $urandom_range(0, 16);
        @(negedge clk);
        if (gap != 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.char_code <= ch;
        in_ch.line_last <= last;
        in_ch.line_empty <= empty;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        items_sent++;
        if (last || empty)
            lines_sent++;
    endtask

    task automatic pause_until_drained();
        @(negedge clk);
        in_ch.valid <= 1'b0;
        wait (pending == 0);
    endtask

    task automatic send_line(input int unsigned len, input line_end_t ending,
                             input bit balanced);
        int unsigned open_now;
        int unsigned remaining;
        int unsigned pos;
        int unsigned pick;
        logic [7:0]  ch;
        open_now = 0;
        for (pos = 0; pos < len; pos++)
        begin
            remaining = len - pos;
            ch = 8'($urandom_range(0, 255));
            if (balanced)
            begin
                pick = $urandom_range(0, 5);
                if (open_now != 0 && (open_now >= remaining || pick >= 2 && pick <= 3))
                begin
                    ch = bmm_pkg::CH_CLOSE;
                    open_now--;
                end
                else if (pick <= 1 && open_now + 1 < remaining)
                begin
                    ch = bmm_pkg::CH_OPEN;
                    open_now++;
                end
            end
            else
            begin
                pick = $urandom_range(0, 9);
                if (pick <= 3)
                    ch = bmm_pkg::CH_OPEN;
                else if (pick <= 7)
                    ch = bmm_pkg::CH_CLOSE;
            end
            push_item(ch, ending == LINE_END_LAST && pos == len - 1, 1'b0);
        end
        if (ending == LINE_END_EMPTY)
            push_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
    endtask

    initial
    begin : receiver
        int unsigned stall;
        int unsigned run_left;
        bit          take_fast;
        bit          hold_taken;
        out_ch.ready = 1'b0;
        run_left = 0;
        take_fast = 1'b0;
        hold_taken = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (run_left == 0)
            begin
                run_left = $urandom_range(4, 16);
                take_fast = ($urandom_range(0, 2) == 0);
            end
            run_left--;
            stall = take_fast ? 0 : $urandom_range(0, 16);
            if (long_hold && !hold_taken)
            begin
                stall = HOLD_CYCLES;
                hold_taken = 1'b1;
            end
            @(negedge clk);
            if (stall != 0)
            begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ch.ready <= 1'b1;
            @(posedge clk);
            while (!out_ch.valid)
                @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no item moved for %0d cycles, %0d marks still awaited",
                     $time, idle_cycles, pending);
            $display("Regression FAIL");
            $finish;
        end
    end

    initial
    begin : stimulus
        int unsigned line_idx;
        int unsigned len;
        int          item_goal;
        line_end_t   ending;
        in_ch.valid = 1'b0;
        in_ch.char_code = 8'h00;
        in_ch.line_last = 1'b0;
        in_ch.line_empty = 1'b0;
        rst_n = 1'b0;
        items_sent = 0;
        lines_sent = 0;
        send_fast = 1'b0;
        long_hold = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed lines: empty, lone brackets, pairs, blanks inside the span,
        // near-bracket codes and lines closed by an empty item.
        push_item(8'h00, 1'b0, 1'b1);
        push_item(bmm_pkg::CH_OPEN, 1'b1, 1'b0);
        push_item(bmm_pkg::CH_CLOSE, 1'b1, 1'b0);
        push_item(bmm_pkg::CH_OPEN, 1'b0, 1'b0);
        push_item(bmm_pkg::CH_CLOSE, 1'b1, 1'b0);
        push_item(bmm_pkg::CH_CLOSE, 1'b0, 1'b0);
        push_item(bmm_pkg::CH_OPEN, 1'b1, 1'b0);
        push_item(bmm_pkg::CH_CLOSE, 1'b0, 1'b0);
        push_item(8'h00, 1'b0, 1'b0);
        push_item(8'hFF, 1'b0, 1'b0);
        push_item(bmm_pkg::CH_OPEN, 1'b1, 1'b0);
        push_item(8'h27, 1'b0, 1'b0);
        push_item(8'h2A, 1'b1, 1'b0);
        push_item(bmm_pkg::CH_OPEN, 1'b0, 1'b0);
        push_item(bmm_pkg::CH_OPEN, 1'b0, 1'b0);
        push_item(bmm_pkg::CH_CLOSE, 1'b1, 1'b1);
        push_item(bmm_pkg::CH_OPEN, 1'b0, 1'b0);
        push_item(bmm_pkg::CH_OPEN, 1'b0, 1'b0);
        push_item(bmm_pkg::CH_CLOSE, 1'b1, 1'b0);
        pause_until_drained();

        item_goal = items_sent + RANDOM_ITEMS;
        line_idx = 0;
        while (items_sent < item_goal)
        begin
            send_fast = (line_idx >= 2 && line_idx <= 4) || ($urandom_range(0, 3) == 0);
            if (line_idx == 2)
                long_hold = 1'b1;
            if (line_idx == 3)
                len = $urandom_range(LINE_CAP + 1, LINE_CAP + 8);
            else if (line_idx == 5)
                len = LINE_CAP;
            else
            begin
                case ($urandom_range(0, 19))
                    0:       len = 0;
                    1:       len = $urandom_range(LINE_CAP - 14, LINE_CAP + 8);
                    default: len = $urandom_range(1, 12);
                endcase
            end
            ending = (len == 0 || $urandom_range(0, 3) == 0) ? LINE_END_EMPTY : LINE_END_LAST;
            send_line(len, ending, 1'($urandom_range(0, 1)));
            if ($urandom_range(0, 15) == 0)
                pause_until_drained();
            line_idx++;
        end

        pause_until_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Sent %0d items in %0d lines, with empty, overlong and early-ended lines.",
                 items_sent, lines_sent);
        $display("Checked %0d marks and %0d line ends.", marks_checked, lines_checked);
        if (failures == 0 && pending == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== bracket_match_marker.f =====
sv/bmm_pkg.sv
sv/bmm_in_if.sv
sv/bmm_out_if.sv
sv/bmm_ctrl.sv
sv/bmm_dp.sv
sv/bracket_match_marker.sv
sv/bmm_checker.sv
bench/bmm_mark_checker.sv
bench/bracket_match_marker_test.sv
